// ----- rtl/lmpf_pkg.sv -----
// Shared constants, types and register codes of the local maximum peak finder.
package lmpf_pkg;

	localparam int MAX_COLS  = 32;
	localparam int MAX_ROWS  = 1024;
	localparam int SAMPLE_W  = 16;
	localparam int ROW_W     = 11;
	localparam int COL_W     = 6;
	localparam int NUM_W     = 16;
	localparam int ADDR_W    = $clog2(MAX_COLS);

	localparam int REG_LSB   = 2;
	localparam int REG_IDX_W = 2;
	localparam int APB_AW    = REG_IDX_W + REG_LSB;
	localparam int APB_DW    = 32;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef logic signed [SAMPLE_W-1:0] smp_t;

	// One line memory word: the row two above and the row one above the incoming row.
	typedef struct packed {
		smp_t up;
		smp_t mid;
	} pair_t;

	typedef struct packed {
		logic             kind;
		logic [ROW_W-1:0] peak_row;
		logic [COL_W-1:0] peak_col;
		logic [NUM_W-1:0] peak_number;
		logic             rescued;
		logic             last;
	} result_t;

	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t word0;
		result_t word1;
	} res_push_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GRID_ROWS  = 2'd0,
		REG_GRID_COLS  = 2'd1,
		REG_TARGET_ROW = 2'd2,
		REG_TARGET_COL = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_VERDICT
	} ctrl_state_t;

	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

endpackage

// ----- rtl/lmpf_intf.sv -----
// Stream interfaces for the sample input and the result output.
interface lmpf_sample_if;
	import lmpf_pkg::*;
	logic valid;
	logic ready;
	smp_t sample;
	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface lmpf_result_if;
	import lmpf_pkg::*;
	logic             valid;
	logic             ready;
	logic             kind;
	logic [ROW_W-1:0] peak_row;
	logic [COL_W-1:0] peak_col;
	logic [NUM_W-1:0] peak_number;
	logic             rescued;
	logic             last;
	modport source(output valid, output kind, output peak_row, output peak_col,
		output peak_number, output rescued, output last, input ready);
	modport sink(input valid, input kind, input peak_row, input peak_col,
		input peak_number, input rescued, input last, output ready);
endinterface

// ----- rtl/local_maximum_peak_finder.sv -----
// Top level: 3x3 strict local maximum finder over a streamed grid, with line memory.
// A sample is accepted every cycle while the result port keeps up; its peak reports
// enter the result queue in the next cycle and can be taken in the cycle after that.
// The last sample of a grid holds off input while it is judged, the final row is
// swept column by column and the verdict word is queued.
// Reset is asynchronous and active low; it clears counters, control and configuration
// registers, while the line memory keeps its contents and is never cleared.
module local_maximum_peak_finder (
	input  logic                        clk,
	input  logic                        arst_n,
	lmpf_sample_if.sink                 samples,
	lmpf_result_if.source               results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lmpf_pkg::APB_AW-1:0] paddr,
	input  logic [lmpf_pkg::APB_DW-1:0] pwdata,
	output logic [lmpf_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import lmpf_pkg::*;

	// Configuration registers.
	logic [ROW_W-1:0] grid_rows_q;
	logic [COL_W-1:0] grid_cols_q;
	logic [ROW_W-1:0] target_row_q;
	logic [COL_W-1:0] target_col_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// Position and sizes.
	logic [ROW_W-1:0]  rows_sat;
	logic [COL_W-1:0]  cols_sat;
	logic [ADDR_W-1:0] col_index_q;
	logic [ROW_W-1:0]  row_index_q;
	logic [ADDR_W-1:0] col_cur;
	logic              row_end;
	logic              last_row;
	logic              in_rdy;
	logic              acc;

	// Evaluation stage.
	logic              s1_valid_q;
	smp_t              sample_s1;
	logic [ADDR_W-1:0] col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              row_end_s1;
	logic              grid_end_s1;
	logic              fwd_s1;
	pair_t             fwd_pair_s1;

	// Line memory.
	pair_t             rd_pair;
	pair_t             cur_pair;
	pair_t             wr_pair;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	smp_t              up_c;
	smp_t              mid_c;

	// Sliding windows of the two previous columns.
	smp_t up_w1_q, up_w2_q, mid_w1_q, mid_w2_q, low_w1_q, low_w2_q;

	// Stream evaluation.
	logic                     has1, has2, up_ok, any_row;
	logic [7:0][SAMPLE_W-1:0] nb_a, nb_b;
	logic                     pk_a, pk_b;

	// Final-row sweep.
	ctrl_state_t              state_q, state_d;
	logic [COL_W-1:0]         fl_step_q;
	logic [ROW_W-1:0]         fl_row_q;
	pair_t                    fl_prev_q, fl_cur_q;
	logic                     room, fl_go, vd_go, fl_rd_en;
	logic                     fl_left, fl_right, fl_eval, fl_up_ok;
	logic [7:0][SAMPLE_W-1:0] nb_f;
	logic                     pk_f;
	logic [COL_W-1:0]         fl_col1;

	// Counting and results.
	logic [NUM_W-1:0]   total_q;
	logic               tgt_hit_q;
	logic [NUM_W-1:0]   num1, num2;
	logic               hit_a, hit_b, hit_f, hit_any;
	res_push_t          push;
	logic [FIFO_CW-1:0] fifo_count;

	function automatic smp_t gate(smp_t v, logic en);
		return en ? v : smp_t'(0);
	endfunction

	function automatic logic beats(smp_t v, logic [7:0][SAMPLE_W-1:0] nb);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			ok = ok && (v > $signed(nb[i]));
		end
		return ok;
	endfunction

	function automatic result_t make_peak(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
		logic [NUM_W-1:0] n);
		result_t w;
		w.kind        = KIND_PEAK;
		w.peak_row    = r;
		w.peak_col    = c;
		w.peak_number = n;
		w.rescued     = 1'b0;
		w.last        = 1'b0;
		return w;
	endfunction

	// ---------------------------------------------------------------- config port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q  <= ROW_W'(1);
			grid_cols_q  <= COL_W'(1);
			target_row_q <= '0;
			target_col_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_GRID_ROWS:  grid_rows_q  <= pwdata[ROW_W-1:0];
				REG_GRID_COLS:  grid_cols_q  <= pwdata[COL_W-1:0];
				REG_TARGET_ROW: target_row_q <= pwdata[ROW_W-1:0];
				REG_TARGET_COL: target_col_q <= pwdata[COL_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_GRID_ROWS:  prdata = APB_DW'(grid_rows_q);
			REG_GRID_COLS:  prdata = APB_DW'(grid_cols_q);
			REG_TARGET_ROW: prdata = APB_DW'(target_row_q);
			REG_TARGET_COL: prdata = APB_DW'(target_col_q);
		endcase
	end

	// ---------------------------------------------------------------- position
	always_comb begin
		if (grid_rows_q == '0) begin
			rows_sat = ROW_W'(1);
		end else if (grid_rows_q > ROW_W'(MAX_ROWS)) begin
			rows_sat = ROW_W'(MAX_ROWS);
		end else begin
			rows_sat = grid_rows_q;
		end
		if (grid_cols_q == '0) begin
			cols_sat = COL_W'(1);
		end else if (grid_cols_q > COL_W'(MAX_COLS)) begin
			cols_sat = COL_W'(MAX_COLS);
		end else begin
			cols_sat = grid_cols_q;
		end
	end

	// A column beyond a narrowed grid ends the row.
	assign col_cur  = (COL_W'(col_index_q) >= cols_sat) ?
		ADDR_W'(cols_sat - COL_W'(1)) : col_index_q;
	assign row_end  = (COL_W'(col_cur) == cols_sat - COL_W'(1));
	assign last_row = ((ROW_W+1)'(row_index_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(rows_sat);

	// Room is kept for two words from the stage in flight and two from the new word.
	assign in_rdy = (state_q == ST_RUN) && !(s1_valid_q && grid_end_s1) &&
		((FIFO_CW+1)'(fifo_count) + (s1_valid_q ? (FIFO_CW+1)'(4) : (FIFO_CW+1)'(2))
		<= (FIFO_CW+1)'(FIFO_DEPTH));
	assign samples.ready = in_rdy;
	assign acc = samples.valid && in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_index_q <= '0;
			row_index_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				col_index_q <= '0;
				row_index_q <= last_row ? '0 : row_index_q + ROW_W'(1);
			end else begin
				col_index_q <= col_cur + ADDR_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1   <= samples.sample;
			col_s1      <= col_cur;
			row_s1      <= row_index_q;
			row_end_s1  <= row_end;
			grid_end_s1 <= row_end && last_row;
			// The word in flight writes the entry this read fetches; pass its data over.
			fwd_s1      <= s1_valid_q && (col_s1 == col_cur);
			fwd_pair_s1 <= wr_pair;
		end
	end

	assign cur_pair = fwd_s1 ? fwd_pair_s1 : rd_pair;
	assign up_c     = cur_pair.up;
	assign mid_c    = cur_pair.mid;

	always_comb begin
		wr_pair.up  = mid_c;
		wr_pair.mid = sample_s1;
	end

	assign ram_raddr = (state_q == ST_FLUSH) ? fl_step_q[ADDR_W-1:0] : col_cur;
	assign ram_re    = acc || fl_rd_en;

	lmpf_ram #(
		.WIDTH($bits(pair_t)),
		.DEPTH(MAX_COLS)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_valid_q),
		.waddr(col_s1),
		.wdata(wr_pair),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_pair)
	);

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			up_w2_q  <= up_w1_q;
			up_w1_q  <= up_c;
			mid_w2_q <= mid_w1_q;
			mid_w1_q <= mid_c;
			low_w2_q <= low_w1_q;
			low_w1_q <= sample_s1;
		end
	end

	// Cell up and left of the new sample is judged now; at a row end, the cell above the sample too.
	always_comb begin
		has1    = (col_s1 != '0);
		has2    = (col_s1 > ADDR_W'(1));
		up_ok   = (row_s1 > ROW_W'(1));
		any_row = (row_s1 != '0);
		nb_a = {gate(up_w2_q, up_ok && has2), gate(up_w1_q, up_ok), gate(up_c, up_ok),
			gate(mid_w2_q, has2), mid_c, gate(low_w2_q, has2), low_w1_q, sample_s1};
		nb_b = {gate(up_w1_q, up_ok && has1), gate(up_c, up_ok), smp_t'(0),
			gate(mid_w1_q, has1), smp_t'(0), gate(low_w1_q, has1), sample_s1, smp_t'(0)};
		pk_a = s1_valid_q && any_row && has1 && beats(mid_w1_q, nb_a);
		pk_b = s1_valid_q && any_row && row_end_s1 && beats(mid_c, nb_b);
	end

	// ---------------------------------------------------------------- final-row sweep
	assign room = (fifo_count < FIFO_CW'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fl_go   = 1'b0;
		vd_go   = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (s1_valid_q && grid_end_s1) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				fl_go = room;
				if (room && (fl_step_q == cols_sat + COL_W'(1))) begin
					state_d = ST_VERDICT;
				end
			end
			ST_VERDICT: begin
				vd_go = room;
				if (room) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	assign fl_rd_en = fl_go && (fl_step_q < cols_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_step_q <= '0;
		end else if (state_q != ST_FLUSH) begin
			fl_step_q <= '0;
		end else if (fl_go) begin
			fl_step_q <= fl_step_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && grid_end_s1) begin
			fl_row_q <= row_s1;
		end
		if (fl_go) begin
			fl_prev_q <= fl_cur_q;
			fl_cur_q  <= rd_pair;
		end
	end

	// At step i the read data holds column i-1 and the cell in column i-2 is judged.
	always_comb begin
		fl_left  = (fl_step_q >= COL_W'(3));
		fl_right = (fl_step_q <= cols_sat);
		fl_eval  = (fl_step_q >= COL_W'(2));
		fl_up_ok = (fl_row_q != '0);
		fl_col1  = fl_step_q - COL_W'(1);
		nb_f = {gate(fl_prev_q.up, fl_up_ok && fl_left), gate(fl_cur_q.up, fl_up_ok),
			gate(rd_pair.up, fl_up_ok && fl_right), gate(fl_prev_q.mid, fl_left),
			gate(rd_pair.mid, fl_right), smp_t'(0), smp_t'(0), smp_t'(0)};
		pk_f = fl_go && fl_eval && beats(fl_cur_q.mid, nb_f);
	end

	// ---------------------------------------------------------------- results
	always_comb begin
		num1  = total_q + NUM_W'(1);
		num2  = total_q + NUM_W'(2);
		hit_a = (row_s1 == target_row_q) && (COL_W'(col_s1) == target_col_q);
		hit_b = (row_s1 == target_row_q) && (COL_W'(col_s1) + COL_W'(1) == target_col_q);
		hit_f = (fl_row_q + ROW_W'(1) == target_row_q) && (fl_col1 == target_col_q);
		hit_any = (pk_a && hit_a) || (pk_b && hit_b) || (pk_f && hit_f);
		push = '0;
		priority if (pk_a) begin
			push.push0 = 1'b1;
			push.word0 = make_peak(row_s1, COL_W'(col_s1), num1);
			if (pk_b) begin
				push.push1 = 1'b1;
				push.word1 = make_peak(row_s1, COL_W'(col_s1) + COL_W'(1), num2);
			end
		end else if (pk_b) begin
			push.push0 = 1'b1;
			push.word0 = make_peak(row_s1, COL_W'(col_s1) + COL_W'(1), num1);
		end else if (pk_f) begin
			push.push0 = 1'b1;
			push.word0 = make_peak(fl_row_q + ROW_W'(1), fl_col1, num1);
		end else if (vd_go) begin
			push.push0             = 1'b1;
			push.word0.kind        = KIND_VERDICT;
			push.word0.peak_row    = '0;
			push.word0.peak_col    = '0;
			push.word0.peak_number = total_q;
			push.word0.rescued     = !tgt_hit_q;
			push.word0.last        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			tgt_hit_q <= 1'b0;
		end else if (vd_go) begin
			total_q   <= '0;
			tgt_hit_q <= 1'b0;
		end else begin
			total_q <= total_q + NUM_W'(push.push0) + NUM_W'(push.push1);
			if (hit_any) begin
				tgt_hit_q <= 1'b1;
			end
		end
	end

	lmpf_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.results(results),
		.count  (fifo_count)
	);

	// ---------------------------------------------------------------- assertions
	a_grid_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && grid_end_s1) |=> (state_q == ST_FLUSH))
		else $error("grid end did not start the final-row sweep");

	a_sweep_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (fl_step_q <= cols_sat + COL_W'(1)))
		else $error("final-row sweep ran past the grid width");

	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind) |-> (results.last && (results.peak_row == '0)))
		else $error("verdict word malformed");

	a_same_entry_forwarded: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && $past(s1_valid_q) && (col_s1 == $past(col_s1))) |-> fwd_s1)
		else $error("back-to-back access to one line entry not forwarded");

endmodule

// ----- rtl/lmpf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read-first data.
module lmpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/lmpf_res_fifo.sv -----
// Result queue that takes up to two words a cycle and drives the result port.
module lmpf_res_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lmpf_pkg::res_push_t        push,
	lmpf_result_if.source              results,
	output logic [lmpf_pkg::FIFO_CW-1:0] count
);
	import lmpf_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   head_q;
	logic [FIFO_AW-1:0]   tail_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;
	result_t              head_word;

	assign pop = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[tail_q] <= push.word0;
		end
		if (push.push1) begin
			mem_q[tail_q + FIFO_AW'(1)] <= push.word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
			head_q  <= head_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(push.push0) + FIFO_CW'(push.push1) - FIFO_CW'(pop);
		end
	end

	assign head_word           = mem_q[head_q];
	assign results.valid       = (count_q != '0);
	assign results.kind        = head_word.kind;
	assign results.peak_row    = head_word.peak_row;
	assign results.peak_col    = head_word.peak_col;
	assign results.peak_number = head_word.peak_number;
	assign results.rescued     = head_word.rescued;
	assign results.last        = head_word.last;
	assign count               = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second word pushed without the first");

endmodule
